[rtl/core/seb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seb_pkg
// Shared widths, limits and types for the sobel edge threshold core.
// ----------------------------------------------------------------------------
package seb_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int PIX_W = 8;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int CFG_W = 11;
	// |sobel sum| is at most 4 * 255
	localparam int MAG_W = PIX_W + 2;

	localparam logic [CFG_W-1:0] WIDTH_MIN    = CFG_W'(3);
	localparam logic [CFG_W-1:0] WIDTH_MAX    = CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] THRESH_RESET = CFG_W'(255);
	localparam logic [ROW_W-1:0] ROW_LAST     = ROW_W'(MAX_HEIGHT - 1);

	// configuration register index
	typedef enum logic {
		REG_IMAGE_WIDTH    = 1'b0,
		REG_EDGE_THRESHOLD = 1'b1
	} cfg_reg_t;

	// write side of the two line buffers
	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
		logic [PIX_W-1:0] upper;
		logic [PIX_W-1:0] middle;
	} lb_wr_t;

endpackage

[rtl/core/seb_linebuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seb_linebuf
// Two row buffers in synchronous ram with registered read and write forwarding.
// ----------------------------------------------------------------------------
module seb_linebuf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [seb_pkg::COL_W-1:0]   rd_addr,
	input  seb_pkg::lb_wr_t             wr,
	output logic [seb_pkg::PIX_W-1:0]   top,
	output logic [seb_pkg::PIX_W-1:0]   mid
);
	import seb_pkg::*;

	logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

	logic [PIX_W-1:0] upper_rd_q;
	logic [PIX_W-1:0] middle_rd_q;
	logic [PIX_W-1:0] fwd_upper_q;
	logic [PIX_W-1:0] fwd_middle_q;
	logic             fwd_hit_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			upper_mem[wr.addr]  <= wr.upper;
			middle_mem[wr.addr] <= wr.middle;
		end
		if (rd_en) begin
			upper_rd_q   <= upper_mem[rd_addr];
			middle_rd_q  <= middle_mem[rd_addr];
			fwd_upper_q  <= wr.upper;
			fwd_middle_q <= wr.middle;
		end
	end

	// same column read while the previous beat writes it back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (rd_en) begin
			fwd_hit_q <= wr.en && (wr.addr == rd_addr);
		end
	end

	assign top = fwd_hit_q ? fwd_upper_q  : upper_rd_q;
	assign mid = fwd_hit_q ? fwd_middle_q : middle_rd_q;

endmodule

[rtl/core/sobel_edge_threshold_core.sv]
`timescale 1ns / 1ps
// a result is built from the pixel one row and column past its center: that pixel passes the stage 1
// registers, the window and the stage 3 magnitude registers, and then enters the output register
// throughput: one pixel per cycle, set by the single read-modify-write of the line buffer rams
// a full output register that is not taken holds the whole pipeline
// reset clears counters, window, valids and config to 640 / 255; the rams are not cleared
// ----------------------------------------------------------------------------
// sobel_edge_threshold_core
// 3x3 sobel gradients on a raster pixel stream, thresholded into edge flags.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [seb_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] pixel
	input  logic                       s_tuser,   // [0] frame_start
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [0] vertical_edge, [1] horizontal_edge, [2] combined_edge,
	// [14:3] center_row, [24:15] center_col, [31:25] zero
	output logic [31:0]                m_tdata
);
	import seb_pkg::*;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] thresh_q;
	logic [CFG_W-1:0] cfg_width_clamped;

	always_comb begin
		if (cfg_data < WIDTH_MIN)
			cfg_width_clamped = WIDTH_MIN;
		else if (cfg_data > WIDTH_MAX)
			cfg_width_clamped = WIDTH_MAX;
		else
			cfg_width_clamped = cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:    width_q  <= cfg_width_clamped;
				REG_EDGE_THRESHOLD: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- handshake ----------------
	logic adv;
	logic accept;
	logic out_valid_q;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	// ---------------- position counters ----------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] c_cur;
	logic [ROW_W-1:0] r_cur;
	logic [ROW_W-1:0] row_inc;
	logic [ROW_W-1:0] r_inc;
	logic [COL_W:0]   c_next;

	assign row_inc = (row_q == ROW_LAST) ? row_q : row_q + 1'b1;

	always_comb begin
		if (s_tuser) begin
			c_cur = '0;
			r_cur = '0;
		end else if ({1'b0, col_q} >= width_q) begin
			c_cur = '0;
			r_cur = row_inc;
		end else begin
			c_cur = col_q;
			r_cur = row_q;
		end
	end

	assign r_inc  = (r_cur == ROW_LAST) ? r_cur : r_cur + 1'b1;
	assign c_next = {1'b0, c_cur} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (c_next >= width_q) begin
				col_q <= '0;
				row_q <= r_inc;
			end else begin
				col_q <= c_next[COL_W-1:0];
				row_q <= r_cur;
			end
		end
	end

	// ---------------- stage 1: line buffer read ----------------
	logic             valid_s1;
	logic             emit_s1;
	logic             border_s1;
	logic [COL_W-1:0] addr_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [PIX_W-1:0] lb_top;
	logic [PIX_W-1:0] lb_mid;
	lb_wr_t           lb_wr;

	assign lb_wr.en     = valid_s1 && adv;
	assign lb_wr.addr   = addr_s1;
	assign lb_wr.upper  = lb_mid;
	assign lb_wr.middle = pix_s1;

	seb_linebuf u_linebuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (c_cur),
		.wr      (lb_wr),
		.top     (lb_top),
		.mid     (lb_mid)
	);

	// ---------------- window and later stages ----------------
	logic [PIX_W-1:0] win_q [3][3];
	logic             valid_s2;
	logic             border_s2;
	logic [COL_W-1:0] col_s2;
	logic [ROW_W-1:0] row_s2;
	logic             valid_s3;
	logic             border_s3;
	logic [COL_W-1:0] col_s3;
	logic [ROW_W-1:0] row_s3;
	logic [MAG_W-1:0] av_s3;
	logic [MAG_W-1:0] ah_s3;

	logic [2:0]       out_flags_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 3; k++)
				for (int j = 0; j < 3; j++)
					win_q[k][j] <= '0;
		end else if (adv) begin
			valid_s1    <= s_tvalid;
			valid_s2    <= valid_s1 && emit_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
			if (valid_s1) begin
				for (int k = 0; k < 3; k++) begin
					win_q[k][0] <= win_q[k][1];
					win_q[k][1] <= win_q[k][2];
				end
				win_q[0][2] <= lb_top;
				win_q[1][2] <= lb_mid;
				win_q[2][2] <= pix_s1;
			end
		end
	end

	// gradient sums, each side at most 4 * 255
	logic [MAG_W-1:0] v_pos;
	logic [MAG_W-1:0] v_neg;
	logic [MAG_W-1:0] h_pos;
	logic [MAG_W-1:0] h_neg;
	logic [MAG_W-1:0] av;
	logic [MAG_W-1:0] ah;

	assign v_pos = MAG_W'(win_q[0][2]) + {1'b0, win_q[1][2], 1'b0} + MAG_W'(win_q[2][2]);
	assign v_neg = MAG_W'(win_q[0][0]) + {1'b0, win_q[1][0], 1'b0} + MAG_W'(win_q[2][0]);
	assign h_pos = MAG_W'(win_q[2][0]) + {1'b0, win_q[2][1], 1'b0} + MAG_W'(win_q[2][2]);
	assign h_neg = MAG_W'(win_q[0][0]) + {1'b0, win_q[0][1], 1'b0} + MAG_W'(win_q[0][2]);
	assign av    = (v_pos >= v_neg) ? v_pos - v_neg : v_neg - v_pos;
	assign ah    = (h_pos >= h_neg) ? h_pos - h_neg : h_neg - h_pos;

	logic [MAG_W:0] mag_sum;
	assign mag_sum = {1'b0, av_s3} + {1'b0, ah_s3};

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1   <= c_cur;
			pix_s1    <= s_tdata;
			emit_s1   <= (r_cur != '0) && (c_cur != '0);
			border_s1 <= (r_cur == ROW_W'(1)) || (c_cur == COL_W'(1));
			row_s1    <= r_cur - 1'b1;
			col_s1    <= c_cur - 1'b1;
		end
		if (adv) begin
			border_s2 <= border_s1;
			row_s2    <= row_s1;
			col_s2    <= col_s1;
			border_s3 <= border_s2;
			row_s3    <= row_s2;
			col_s3    <= col_s2;
			av_s3     <= av;
			ah_s3     <= ah;
			out_row_q <= row_s3;
			out_col_q <= col_s3;
			if (border_s3) begin
				out_flags_q <= '0;
			end else begin
				out_flags_q[0] <= {1'b0, av_s3} > thresh_q;
				out_flags_q[1] <= {1'b0, ah_s3} > thresh_q;
				out_flags_q[2] <= mag_sum > thresh_q;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_col_q, out_row_q, out_flags_q};

`ifndef SYNTHESIS
	// center column lies at least two short of the row end
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ({1'b0, out_col_q} + 2'd2 <= {1'b0, width_q}))
		else $error("center column beyond image width");

	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_row_q == '0 || out_col_q == '0) |-> (out_flags_q == '0))
		else $error("border center flagged");

	a_combined_covers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_flags_q[0] || out_flags_q[1]) |-> out_flags_q[2])
		else $error("combined flag missing");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_row_q < ROW_LAST))
		else $error("center row out of range");
`endif

endmodule
